// ===== rtl/nwws_pkg.sv =====
// Package for the nearest waypoint window search unit.
// Holds table sizes, field widths, action codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package nwws_pkg;

  // Path table geometry
  localparam int PATH_DEPTH = 4096;
  localparam int IDX_BITS   = $clog2(PATH_DEPTH);
  localparam int CNT_BITS   = IDX_BITS + 1;

  // Coordinate and distance widths
  localparam int COORD_BITS = 24;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int DIST_BITS  = SQ_BITS + 1;

  // Configuration register widths
  localparam int BACK_BITS  = 12;
  localparam int WIN_BITS   = 13;
  localparam int LIMIT_BITS = 52;
  localparam int CFG_BITS   = LIMIT_BITS;
  localparam int CFG_IDX_BITS = 2;

  // Configuration reset values
  localparam logic [BACK_BITS-1:0]  BACK_SPAN_RESET   = BACK_BITS'(200);
  localparam logic [WIN_BITS-1:0]   WINDOW_LEN_RESET  = WIN_BITS'(400);
  localparam logic [LIMIT_BITS-1:0] MAX_DIST_SQ_RESET = LIMIT_BITS'(1048576);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BACK_SPAN   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DIST_SQ = 2'd2;

  // Request action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

endpackage

// ===== rtl/nwws_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Used for the waypoint table. No dependencies.
`timescale 1ns / 1ps

module nwws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nearest_waypoint_window_search_unit.sv =====
// Top level of the nearest waypoint window search unit.
// Depends on nwws_pkg and nwws_ram (waypoint table).
`timescale 1ns / 1ps

// Usage:
//   A request is taken when start is high and busy is low. action selects
//   clear (empty the path, zero the remembered nearest index), append (store
//   pos_x/pos_y as the next waypoint, dropped when the table is full) or
//   pose query. Clear and append complete without raising busy.
//   A query raises busy and, when finished, drives done high for one cycle
//   with nearest_index, lost and full_search. The receiver cannot stall;
//   a result is valid only in its done cycle.
//   A query scans the local window first; when the window fails, it scans
//   the whole table. A query on an empty table does not raise busy;
//   done follows in the next cycle with lost set.
//   The scan reads one waypoint per cycle through the table RAM's single
//   read port into a five stage distance and compare pipeline.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once.
//   Reset (rst, synchronous) empties the path, restores the register
//   defaults and leaves the table contents undefined.

module nearest_waypoint_window_search_unit
  import nwws_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [CFG_BITS-1:0]         cfg_data,
  output logic                        done,
  output logic [IDX_BITS-1:0]         nearest_index,
  output logic                        lost,
  output logic                        full_search
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_LIMIT = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;

  logic [2:0]             state;
  logic [BACK_BITS-1:0]   back_span;
  logic [WIN_BITS-1:0]    window_len;
  logic [LIMIT_BITS-1:0]  max_dist_sq;
  logic [CNT_BITS-1:0]    point_count;
  logic [IDX_BITS-1:0]    last_nearest;

  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic [IDX_BITS-1:0]    scan_start;
  logic [CNT_BITS-1:0]    scan_end;
  logic [CNT_BITS-1:0]    addr;
  logic                   full_flag;

  // Pipeline stage registers
  logic                   v1, v2, v3, v4;
  logic [IDX_BITS-1:0]    idx1, idx2, idx3, idx4;
  logic [DIFF_BITS-1:0]   ax, ay;
  logic [SQ_BITS-1:0]     sqx, sqy;
  logic [DIST_BITS-1:0]   sum_sq;

  // Running minimum
  logic                   found;
  logic [DIST_BITS-1:0]   best_sq;
  logic [IDX_BITS-1:0]    best;

  logic                        accept;
  logic                        issuing;
  logic                        ram_we;
  logic [2*COORD_BITS-1:0]     ram_rdata;
  logic signed [COORD_BITS-1:0] wx, wy;
  logic signed [DIFF_BITS-1:0] dx, dy;
  logic [CNT_BITS:0]           end_sum;
  logic                        ok;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign issuing = (state == ST_SCAN) && (addr < scan_end);
  assign ram_we  = accept && (action == ACT_APPEND) && (point_count < CNT_BITS'(PATH_DEPTH));

  nwws_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (PATH_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (point_count[IDX_BITS-1:0]),
    .wdata ({pos_x, pos_y}),
    .raddr (addr[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Split table word and form coordinate differences
  always_comb begin
    wx = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    wy = ram_rdata[COORD_BITS-1:0];
    dx = DIFF_BITS'(wx) - DIFF_BITS'(px);
    dy = DIFF_BITS'(wy) - DIFF_BITS'(py);
    end_sum = (CNT_BITS+1)'(scan_start) + (CNT_BITS+1)'(window_len);
    ok = found && ({{(LIMIT_BITS-DIST_BITS){1'b0}}, best_sq} <= max_dist_sq);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      back_span   <= BACK_SPAN_RESET;
      window_len  <= WINDOW_LEN_RESET;
      max_dist_sq <= MAX_DIST_SQ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BACK_SPAN:   back_span   <= cfg_data[BACK_BITS-1:0];
        REG_WINDOW_LEN:  window_len  <= cfg_data[WIN_BITS-1:0];
        REG_MAX_DIST_SQ: max_dist_sq <= cfg_data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Distance pipeline: abs difference, squares, sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    idx1 <= addr[IDX_BITS-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    idx4 <= idx3;
    ax   <= dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
    ay   <= dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
    sqx  <= ax * ax;
    sqy  <= ay * ay;
    sum_sq <= DIST_BITS'(sqx) + DIST_BITS'(sqy);
  end

  // Sequencer, path state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      point_count  <= '0;
      last_nearest <= '0;
      done         <= 1'b0;
      found        <= 1'b0;
      full_flag    <= 1'b0;
      addr         <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (action)
              ACT_CLEAR: begin
                point_count  <= '0;
                last_nearest <= '0;
              end
              ACT_APPEND: begin
                if (ram_we) begin
                  point_count <= point_count + 1'b1;
                end
              end
              ACT_QUERY: begin
                px <= pos_x;
                py <= pos_y;
                if (point_count == '0) begin
                  // empty path: answer lost at once
                  done          <= 1'b1;
                  nearest_index <= '0;
                  lost          <= 1'b1;
                  full_search   <= 1'b0;
                end else begin
                  state <= ST_SETUP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SETUP: begin
          // window start, floored at zero
          scan_start <= (last_nearest > back_span) ? (last_nearest - back_span) : '0;
          found      <= 1'b0;
          full_flag  <= 1'b0;
          state      <= ST_LIMIT;
        end
        ST_LIMIT: begin
          // window end, cut off at the fill count
          scan_end <= (end_sum > (CNT_BITS+1)'(point_count)) ? point_count
                                                             : end_sum[CNT_BITS-1:0];
          addr     <= CNT_BITS'(scan_start);
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (issuing) begin
            addr <= addr + 1'b1;
          end else if (!v1 && !v2 && !v3 && !v4) begin
            state <= ST_CHECK;
          end
          // keep the lowest index with the smallest distance
          if (v4 && (!found || sum_sq < best_sq)) begin
            found   <= 1'b1;
            best_sq <= sum_sq;
            best    <= idx4;
          end
        end
        ST_CHECK: begin
          if (ok) begin
            done          <= 1'b1;
            nearest_index <= best;
            lost          <= 1'b0;
            full_search   <= full_flag;
            last_nearest  <= best;
            state         <= ST_IDLE;
          end else if (!full_flag) begin
            // fall back to the whole table
            full_flag <= 1'b1;
            found     <= 1'b0;
            addr      <= '0;
            scan_end  <= point_count;
            state     <= ST_SCAN;
          end else begin
            done          <= 1'b1;
            nearest_index <= IDX_BITS'(point_count - 1'b1);
            lost          <= 1'b1;
            full_search   <= 1'b1;
            last_nearest  <= IDX_BITS'(point_count - 1'b1);
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
